/* rtl/segment_ellipse_fence_macros.svh */
// assertion macros for the segment ellipse fence
// used by the top level only
`ifndef SEGMENT_ELLIPSE_FENCE_MACROS_SVH
`define SEGMENT_ELLIPSE_FENCE_MACROS_SVH
`ifndef SYNTHESIS
`define SEF_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error("sef check");
`define SEF_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error("sef check");
`else
`define SEF_ASSERT(lbl, clk, rstn, prop)
`define SEF_ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif
`endif

/* rtl/sef_pkg.sv */
// types and constants for the segment ellipse fence
// no dependencies
package sef_pkg;
  localparam int CoordW = 24;
  localparam int CordicSteps = 24;
  localparam logic [29:0] InvGain = 30'd652032874;
  localparam logic [15:0] RadiusReset = 16'd256;
  localparam logic [11:0] RatioReset = 12'd512;
  localparam logic [1:0] RegRadius = 2'd0;
  localparam logic [1:0] RegRatio = 2'd1;

  typedef struct packed {
    logic signed [CoordW-1:0] start_x;
    logic signed [CoordW-1:0] start_y;
    logic signed [CoordW-1:0] end_x;
    logic signed [CoordW-1:0] end_y;
  } sef_in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] centre_x;
    logic signed [CoordW-1:0] centre_y;
    logic [CoordW-1:0] semi_major;
    logic [23:0] semi_minor;
    logic signed [15:0] angle;
    logic last;
    logic capped;
  } sef_out_t;

  // datapath operations chosen by the controller
  typedef enum logic [3:0] {
    OpNone, OpLoad, OpNorm, OpCordic, OpLen, OpCountInit, OpCountStep,
    OpMajInit, OpMajStep, OpOffInit, OpOffStep, OpEmit
  } sef_op_e;

  typedef struct packed {
    sef_op_e op;
    logic    first;
  } sef_cmd_t;

  typedef struct packed {
    logic norm_done;
    logic div_done;
    logic step_done;
    logic last_item;
  } sef_stat_t;

  function automatic logic [31:0] arc(input logic [4:0] i);
    unique case (i)
      5'd0: arc = 32'd536870912;  5'd1: arc = 32'd316933406;
      5'd2: arc = 32'd167458907;  5'd3: arc = 32'd85004756;
      5'd4: arc = 32'd42667331;   5'd5: arc = 32'd21354465;
      5'd6: arc = 32'd10679838;   5'd7: arc = 32'd5340245;
      5'd8: arc = 32'd2670163;    5'd9: arc = 32'd1335087;
      5'd10: arc = 32'd667544;    5'd11: arc = 32'd333772;
      5'd12: arc = 32'd166886;    5'd13: arc = 32'd83443;
      5'd14: arc = 32'd41722;     5'd15: arc = 32'd20861;
      5'd16: arc = 32'd10430;     5'd17: arc = 32'd5215;
      5'd18: arc = 32'd2608;      5'd19: arc = 32'd1304;
      5'd20: arc = 32'd652;       5'd21: arc = 32'd326;
      5'd22: arc = 32'd163;       5'd23: arc = 32'd81;
      default: arc = 32'd0;
    endcase
  endfunction
endpackage

/* rtl/sef_ctrl.sv */
// controller state machine for the segment ellipse fence
// depends on sef_pkg
module sef_ctrl import sef_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic      out_ready_i,
  output logic      out_valid_o,
  input  sef_stat_t stat_i,
  output sef_cmd_t  cmd_o
);
  typedef enum logic [10:0] {
    SIdle   = 11'b00000000001,
    SNorm   = 11'b00000000010,
    SCordic = 11'b00000000100,
    SLen    = 11'b00000001000,
    SCntI   = 11'b00000010000,
    SCnt    = 11'b00000100000,
    SMajI   = 11'b00001000000,
    SMaj    = 11'b00010000000,
    SOffI   = 11'b00100000000,
    SOff    = 11'b01000000000,
    SOut    = 11'b10000000000
  } state_e;

  state_e state_q, state_d;
  logic first_q, first_d;
  logic [4:0] cnt_q, cnt_d;

  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = (state_q == SOut);

  always_comb begin
    state_d = state_q;
    first_d = first_q;
    cnt_d = cnt_q;
    cmd_o.op = OpNone;
    cmd_o.first = first_q;
    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.op = OpLoad;
          state_d = SNorm;
        end
      end
      SNorm: begin
        cmd_o.op = OpNorm;
        cnt_d = '0;
        if (stat_i.norm_done) state_d = SCordic;
      end
      SCordic: begin
        cmd_o.op = OpCordic;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(CordicSteps - 1)) state_d = SLen;
      end
      SLen: begin
        cmd_o.op = OpLen;
        state_d = SCntI;
      end
      SCntI: begin
        cmd_o.op = OpCountInit;
        state_d = SCnt;
      end
      SCnt: begin
        cmd_o.op = OpCountStep;
        if (stat_i.div_done) state_d = SMajI;
      end
      SMajI: begin
        cmd_o.op = OpMajInit;
        state_d = SMaj;
      end
      SMaj: begin
        cmd_o.op = OpMajStep;
        if (stat_i.div_done) begin
          first_d = 1'b1;
          state_d = SOut;
        end
      end
      SOffI: begin
        cmd_o.op = OpOffInit;
        state_d = SOff;
      end
      SOff: begin
        cmd_o.op = OpOffStep;
        if (stat_i.step_done) state_d = SOut;
      end
      SOut: begin
        if (out_ready_i) begin
          cmd_o.op = OpEmit;
          first_d = 1'b0;
          if (stat_i.last_item) state_d = SIdle;
          else state_d = SOffI;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      first_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      first_q <= first_d;
      cnt_q <= cnt_d;
    end
  end
endmodule

/* rtl/sef_datapath.sv */
// datapath: cordic, serial dividers and centre offsets
// depends on sef_pkg
module sef_datapath import sef_pkg::*; #(
  parameter int MaxAlong = 63
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  sef_in_t     in_i,
  input  logic [15:0] radius_i,
  input  logic [11:0] ratio_i,
  input  sef_cmd_t    cmd_i,
  output sef_stat_t   stat_o,
  output sef_out_t    out_o
);
  localparam int DW = CoordW + 1;
  localparam int NW = 7;
  localparam int LW = 34;

  logic signed [CoordW-1:0] sx_q, sy_q;
  logic signed [DW-1:0] dx_q, dy_q;
  logic signed [33:0] x_q, y_q;
  logic [31:0] acc_q;
  logic [5:0] s_q;
  logic [4:0] it_q;
  logic zero_q;
  logic [LW-1:0] len_q;
  logic [15:0] ang_q;
  logic [NW-1:0] n_q, i_q;
  logic capped_q;
  // shared restoring divider
  logic [LW+7:0] num_q;
  logic [LW+7:0] quo_q;
  logic [28:0] dvs_q;
  logic [28:0] rem_q;
  logic [5:0] dcnt_q;
  logic [LW-1:0] maj_q;
  logic [1:0] oph_q;
  logic signed [DW+NW+1:0] offx_q, offy_q;
  logic [64:0] prod_q;

  logic [27:0] dprod;
  assign dprod = 28'(radius_i) * 28'(ratio_i);

  logic signed [33:0] xs, ys;
  assign xs = x_q >>> it_q;
  assign ys = y_q >>> it_q;

  logic [33:0] mag_y, mag_m;
  assign mag_y = y_q[33] ? 34'(-y_q) : 34'(y_q);
  assign mag_m = (34'(x_q) > mag_y) ? 34'(x_q) : mag_y;

  logic [29:0] rtry;
  assign rtry = {rem_q[28:0], num_q[LW+7]} - {1'b0, dvs_q};

  // signed floor division of offsets, by 2(n+1) via serial divider
  logic [DW+NW+1:0] absn;
  logic signed [DW+NW+1:0] numx_s;
  assign numx_s = oph_q[0] ? offy_q : offx_q;
  // floor for negatives: -(q) - (rem!=0)
  assign absn = numx_s[DW+NW+1] ? (DW+NW+2)'(-quo_q - (LW+8)'(rem_q != '0))
                                : (DW+NW+2)'(quo_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
      it_q <= '0;
    end else begin
      unique case (cmd_i.op)
        OpLoad: begin
          sx_q <= in_i.start_x;
          sy_q <= in_i.start_y;
          dx_q <= DW'(in_i.end_x) - DW'(in_i.start_x);
          dy_q <= DW'(in_i.end_y) - DW'(in_i.start_y);
          if (in_i.end_x < in_i.start_x) begin
            x_q <= -(34'(in_i.end_x) - 34'(in_i.start_x));
            y_q <= -(34'(in_i.end_y) - 34'(in_i.start_y));
            acc_q <= 32'h8000_0000;
          end else begin
            x_q <= 34'(in_i.end_x) - 34'(in_i.start_x);
            y_q <= 34'(in_i.end_y) - 34'(in_i.start_y);
            acc_q <= '0;
          end
          zero_q <= (in_i.end_x == in_i.start_x) && (in_i.end_y == in_i.start_y);
          s_q <= '0;
          it_q <= '0;
        end
        OpNorm: begin
          if (!zero_q && !mag_m[30]) begin
            x_q <= x_q <<< 1;
            y_q <= y_q <<< 1;
            s_q <= s_q + 6'd1;
          end
        end
        OpCordic: begin
          it_q <= it_q + 5'd1;
          if (y_q > 0) begin
            x_q <= x_q + ys;
            y_q <= y_q - xs;
            acc_q <= acc_q + arc(it_q);
          end else begin
            x_q <= x_q - ys;
            y_q <= y_q + xs;
            acc_q <= acc_q - arc(it_q);
          end
        end
        OpLen: begin
          prod_q <= 65'(x_q[33] ? 34'd0 : 34'(x_q)) * 65'(InvGain);
        end
        OpCountInit: begin
          if (zero_q) begin
            len_q <= '0;
            ang_q <= '0;
          end else begin
            len_q <= LW'((prod_q + (65'd1 << (29 + s_q))) >> (30 + s_q));
            ang_q <= 16'((acc_q + 32'h8000) >> 16);
          end
          num_q <= '0;
          quo_q <= '0;
          rem_q <= '0;
          dvs_q <= 29'(dprod);
          dcnt_q <= '0;
        end
        OpCountStep: begin
          if (dcnt_q == 6'd0) num_q <= {len_q, 7'd0, 1'b0};
          else begin
            num_q <= num_q << 1;
            if (!rtry[29]) begin
              rem_q <= rtry[28:0];
              quo_q <= {quo_q[LW+6:0], 1'b1};
            end else begin
              rem_q <= {rem_q[27:0], num_q[LW+7]};
              quo_q <= {quo_q[LW+6:0], 1'b0};
            end
          end
          dcnt_q <= dcnt_q + 6'd1;
        end
        OpMajInit: begin
          if (dvs_q == '0 || quo_q >= (LW+8)'(MaxAlong)) begin
            n_q <= NW'(MaxAlong);
            capped_q <= 1'b1;
          end else begin
            n_q <= NW'(quo_q) + NW'(1);
            capped_q <= 1'b0;
          end
          num_q <= '0;
          quo_q <= '0;
          rem_q <= '0;
          dcnt_q <= '0;
          i_q <= '0;
        end
        OpMajStep: begin
          if (dcnt_q == 6'd0) begin
            num_q <= (LW+8)'(len_q) << 8;
            dvs_q <= 29'(n_q) + 29'd1;
          end else begin
            num_q <= num_q << 1;
            if (!rtry[29]) begin
              rem_q <= rtry[28:0];
              quo_q <= {quo_q[LW+6:0], 1'b1};
            end else begin
              rem_q <= {rem_q[27:0], num_q[LW+7]};
              quo_q <= {quo_q[LW+6:0], 1'b0};
            end
          end
          if (dcnt_q == 6'(LW)) maj_q <= LW'({quo_q[LW-2:0], !rtry[29]});
          dcnt_q <= dcnt_q + 6'd1;
        end
        OpOffInit: begin
          i_q <= i_q + NW'(1);
          offx_q <= (DW+NW+2)'(2) * (DW+NW+2)'(i_q + NW'(1)) * (DW+NW+2)'(dx_q)
                    + (DW+NW+2)'(n_q) + (DW+NW+2)'(1);
          offy_q <= (DW+NW+2)'(2) * (DW+NW+2)'(i_q + NW'(1)) * (DW+NW+2)'(dy_q)
                    + (DW+NW+2)'(n_q) + (DW+NW+2)'(1);
          dvs_q <= (29'(n_q) + 29'd1) << 1;
          oph_q <= '0;
          dcnt_q <= '0;
        end
        OpOffStep: begin
          if (dcnt_q == 6'd0) begin
            num_q <= (LW+8)'(numx_s[DW+NW+1] ? -numx_s : numx_s) << (LW+8-(DW+NW+2));
            rem_q <= '0;
            quo_q <= '0;
          end else if (dcnt_q <= 6'(DW+NW+2)) begin
            num_q <= num_q << 1;
            if (!rtry[29]) begin
              rem_q <= rtry[28:0];
              quo_q <= {quo_q[LW+6:0], 1'b1};
            end else begin
              rem_q <= {rem_q[27:0], num_q[LW+7]};
              quo_q <= {quo_q[LW+6:0], 1'b0};
            end
          end else begin
            if (oph_q[0]) offy_q <= absn;
            else offx_q <= absn;
            oph_q <= oph_q + 2'd1;
          end
          dcnt_q <= (dcnt_q > 6'(DW+NW+2)) ? 6'd0 : dcnt_q + 6'd1;
        end
        OpEmit: ;
        default: ;
      endcase
    end
  end

  always_comb begin
    stat_o.norm_done = zero_q || mag_m[30];
    // count division runs on through the seven zero bits of the 128 scale
    stat_o.div_done = (dcnt_q == ((cmd_i.op == OpCountStep) ? 6'(LW+7) : 6'(LW)));
    stat_o.step_done = (dcnt_q > 6'(DW+NW+2)) && oph_q[0];
    stat_o.last_item = !cmd_i.first && (i_q == n_q);
    if (cmd_i.first) begin
      out_o.centre_x = sx_q;
      out_o.centre_y = sy_q;
      out_o.semi_major = CoordW'(radius_i);
      out_o.angle = '0;
      out_o.last = 1'b0;
    end else begin
      out_o.centre_x = sx_q + CoordW'(offx_q);
      out_o.centre_y = sy_q + CoordW'(offy_q);
      out_o.semi_major = CoordW'(maj_q);
      out_o.angle = ang_q;
      out_o.last = (i_q == n_q);
    end
    out_o.semi_minor = 24'(radius_i);
    out_o.capped = capped_q;
  end
endmodule

/* rtl/segment_ellipse_fence.sv */
// top level of the segment ellipse fence: register port, controller, datapath
// depends on sef_pkg, sef_ctrl, sef_datapath and the macro header
`include "segment_ellipse_fence_macros.svh"
// One edge request gives a start circle then n ellipses (n up to MAX_ALONG).
// An edge is accepted, normalized, rotated in the cordic steps, given its
// length and count setup, divided serially for the count, set up once more
// and divided serially for the spacing before the start circle is shown.
// Each further ellipse takes a setup, two serial offset divisions and an
// output, and waits in the output state while the receiver stalls. One
// edge is in flight at a time.
module segment_ellipse_fence import sef_pkg::*; #(
  parameter int MAX_ALONG = 63
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  sef_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output sef_out_t    out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [15:0] radius_q;
  logic [11:0] ratio_q;
  sef_cmd_t cmd;
  sef_stat_t stat;

  assign pready = 1'b1;
  always_comb begin
    unique case (paddr[2:2])
      RegRadius[0]: prdata = 32'(radius_q);
      default: prdata = 32'(ratio_q);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RadiusReset;
      ratio_q <= RatioReset;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
      if (paddr[2:2] == RegRadius[0]) radius_q <= pwdata[15:0];
      else if (paddr[2:2] == RegRatio[0]) ratio_q <= pwdata[11:0];
    end
  end

  sef_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_ready_i, .out_valid_o,
    .stat_i(stat), .cmd_o(cmd)
  );

  sef_datapath #(.MaxAlong(MAX_ALONG)) u_dp (
    .clk_i, .rst_ni, .in_i(in_data_i), .radius_i(radius_q), .ratio_i(ratio_q),
    .cmd_i(cmd), .stat_o(stat), .out_o(out_data_o)
  );

  `SEF_ASSERT(a_no_both, clk_i, rst_ni, !(in_ready_o && out_valid_o))
  `SEF_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
endmodule
